[rtl/iors_pkg.sv]
// Shared constants, types and helpers of the I/O request splitter.
`timescale 1ns / 1ps

package iors_pkg;

    localparam int SECTOR_LOG2 = 9;
    localparam int COUNT_BITS  = 8;
    localparam int CAP_MIN     = 2;
    localparam int CAP_MAX     = 8;
    localparam int MAX_CHUNKS  = 64;
    localparam int CHUNK_IDX_W = $clog2(MAX_CHUNKS);
    localparam int SCAN_W      = CAP_MAX + 1;

    localparam int BLOCK_W = 32;
    localparam int LOG2_W  = 4;
    localparam int LEN_W   = 5;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_READ  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WRITE = CFG_IDX_W'(1);

    localparam logic [CFG_DAT_W-1:0] CAP_RESET = CFG_DAT_W'(7);

    typedef struct packed {
        logic load;   // take a new request into the working registers
        logic step;   // emit one chunk into the output register
    } iors_cmd_t;

    typedef struct packed {
        logic count_zero;  // incoming request has no sectors
        logic chunk_last;  // chunk being formed closes the request
    } iors_stat_t;

    // Limit a programmed cap to the supported range.
    function automatic logic [LOG2_W-1:0] clamp_cap(input logic [CFG_DAT_W-1:0] v);
        logic [LOG2_W-1:0] r;
        if (v < CFG_DAT_W'(CAP_MIN)) begin
            r = LOG2_W'(CAP_MIN);
        end else if (v > CFG_DAT_W'(CAP_MAX)) begin
            r = LOG2_W'(CAP_MAX);
        end else begin
            r = LOG2_W'(v);
        end
        return r;
    endfunction

endpackage

[rtl/iors_dp.sv]
// Datapath of the request splitter: working registers, chunk sizing, output register.
`timescale 1ns / 1ps

module iors_dp import iors_pkg::*; (
    input  logic                   aclk,
    input  iors_cmd_t              cmd,
    output iors_stat_t             stat,
    input  logic                   in_write,
    input  logic [BLOCK_W-1:0]     in_block,
    input  logic [COUNT_BITS-1:0]  in_count,
    input  logic [CFG_DAT_W-1:0]   max_read_log2,
    input  logic [CFG_DAT_W-1:0]   max_write_log2,
    output logic [BLOCK_W-1:0]     chunk_block,
    output logic [LOG2_W-1:0]      chunk_log2,
    output logic [LEN_W-1:0]       byte_log2,
    output logic                   chunk_is_write,
    output logic                   last_chunk
);

    logic [COUNT_BITS-1:0]  remain_reg, remain_next;
    logic [BLOCK_W-1:0]     addr_reg;
    logic                   write_reg;
    logic [LOG2_W-1:0]      cap_reg;
    logic [CHUNK_IDX_W-1:0] n_reg;

    logic [BLOCK_W-1:0]     out_block_reg;
    logic [LOG2_W-1:0]      out_log2_reg;
    logic [LEN_W-1:0]       out_len_reg;
    logic                   out_write_reg;
    logic                   out_last_reg;

    logic [COUNT_BITS+SCAN_W-1:0] remain_wide;
    logic [SCAN_W-1:0]            scan;
    logic [LOG2_W-1:0]            lg;
    logic [COUNT_BITS:0]          size_cnt;
    logic [BLOCK_W-1:0]           size_blk;

    assign remain_wide = {{SCAN_W{1'b0}}, remain_reg};
    assign scan        = remain_wide[SCAN_W-1:0];

    // Lowest set bit of the remaining count, stopped at the cap.
    always_comb begin
        logic found;
        found = 1'b0;
        lg    = LOG2_W'(CAP_MAX);
        for (int i = 0; i < SCAN_W; i++) begin
            if (!found && (scan[i] || (LOG2_W'(i) == cap_reg))) begin
                lg    = LOG2_W'(i);
                found = 1'b1;
            end
        end
    end

    assign size_cnt    = (COUNT_BITS+1)'(1) << lg;
    assign size_blk    = BLOCK_W'(1) << lg;
    assign remain_next = remain_reg - size_cnt[COUNT_BITS-1:0];

    assign stat.count_zero = (in_count == '0);
    assign stat.chunk_last = (remain_next == '0) || (n_reg == CHUNK_IDX_W'(MAX_CHUNKS - 1));

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            remain_reg <= in_count;
            addr_reg   <= in_block;
            write_reg  <= in_write;
            cap_reg    <= clamp_cap(in_write ? max_write_log2 : max_read_log2);
            n_reg      <= '0;
        end else if (cmd.step) begin
            remain_reg <= remain_next;
            addr_reg   <= addr_reg + size_blk;
            n_reg      <= n_reg + CHUNK_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            out_block_reg <= addr_reg;
            out_log2_reg  <= lg;
            out_len_reg   <= LEN_W'(lg) + LEN_W'(SECTOR_LOG2);
            out_write_reg <= write_reg;
            out_last_reg  <= stat.chunk_last;
        end
    end

    assign chunk_block    = out_block_reg;
    assign chunk_log2     = out_log2_reg;
    assign byte_log2      = out_len_reg;
    assign chunk_is_write = out_write_reg;
    assign last_chunk     = out_last_reg;

endmodule

[rtl/iors_ctrl.sv]
// Controller of the request splitter: request/run sequencing and output beat valid.
`timescale 1ns / 1ps

module iors_ctrl import iors_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  iors_stat_t stat,
    output iors_cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cmd.load  = s_tvalid && s_tready;
    assign cmd.step  = (state_reg == ST_RUN) && slot_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load && !stat.count_zero) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (cmd.step && stat.chunk_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.step) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/io_request_splitter_core.sv]
// Top level of the I/O request splitter: ports, cap registers, controller and datapath.
`timescale 1ns / 1ps
//
//  channel  | dir | handshake           | content
//  ---------+-----+---------------------+------------------------------------------
//  s_       | in  | s_tvalid / s_tready | request: start sector, count, direction
//  m_       | out | m_tvalid / m_tready | chunk: start, log2 size, byte log2, last
//  cfg_     | in  | cfg_valid/cfg_ready | cap register write (index, data)
//
//  A request is taken in by one load and then one chunk-sizing step per chunk;
//  a zero count is accepted and emits nothing. One chunk-sizing step forms
//  one chunk per cycle while the output register is free to take it.
//  aresetn is synchronous, active low; it clears the controller and restores
//  both caps to 128 sectors. A stalled m_ beat holds in the output register;
//  the next request is accepted while the final chunk of the previous one waits.

module io_request_splitter_core import iors_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // [31:0] start_block, [39:32] block_count
    input  logic                  s_tuser,   // [0] req_type (1 write)

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // [31:0] chunk_block, [35:32] chunk_log2,
                                             // [40:36] byte_log2, [47:41] zero
    output logic                  m_tuser,   // [0] chunk_is_write
    output logic                  m_tlast,   // last_chunk

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    logic [CFG_DAT_W-1:0] max_read_log2_reg;
    logic [CFG_DAT_W-1:0] max_write_log2_reg;

    iors_cmd_t  cmd;
    iors_stat_t stat;

    logic [BLOCK_W-1:0] chunk_block;
    logic [LOG2_W-1:0]  chunk_log2;
    logic [LEN_W-1:0]   byte_log2;

    // Cap registers; writes are always taken, unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_read_log2_reg  <= CAP_RESET;
            max_write_log2_reg <= CAP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_MAX_READ:  max_read_log2_reg  <= cfg_data;
                REG_MAX_WRITE: max_write_log2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    iors_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    iors_dp u_dp (
        .aclk           (aclk),
        .cmd            (cmd),
        .stat           (stat),
        .in_write       (s_tuser),
        .in_block       (s_tdata[31:0]),
        .in_count       (s_tdata[39:32]),
        .max_read_log2  (max_read_log2_reg),
        .max_write_log2 (max_write_log2_reg),
        .chunk_block    (chunk_block),
        .chunk_log2     (chunk_log2),
        .byte_log2      (byte_log2),
        .chunk_is_write (m_tuser),
        .last_chunk     (m_tlast)
    );

    // Pack the output beat, zero-filled to whole bytes.
    assign m_tdata = {7'b0, byte_log2, chunk_log2, chunk_block};

    // Never load a request and emit a chunk in the same cycle.
    a_load_step_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.step))
        else $error("request load and chunk step overlap");

    // A chunk that does not close the request keeps the input side closed.
    a_busy_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && !stat.chunk_last) |=> !s_tready)
        else $error("input reopened before the last chunk");

    // Byte length log2 follows the sector size of the chunk.
    a_byte_log2: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (byte_log2 == LEN_W'(chunk_log2) + LEN_W'(SECTOR_LOG2)))
        else $error("byte_log2 does not match chunk_log2");

    // No chunk exceeds the largest supported cap.
    a_chunk_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (chunk_log2 <= LOG2_W'(CAP_MAX)))
        else $error("chunk larger than the maximum cap");

endmodule

[tb/io_request_splitter_core_tb.sv]
// Self-checking testbench for the I/O request splitter core.
`timescale 1ns / 1ps

module io_request_splitter_core_tb import iors_pkg::*; ();

    // One expected chunk beat on the m_ side, fields at the block's widths.
    typedef struct {
        logic [BLOCK_W-1:0] blk;
        logic [LOG2_W-1:0]  lg;
        logic [LEN_W-1:0]   lenp;
        logic               wr;
        logic               last;
    } chunk_t;

    logic                 aclk;
    logic                 aresetn;

    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // [31:0] start_block, [39:32] block_count
    logic                 s_tuser;   // [0] req_type (1 write)

    logic                 m_tvalid;
    logic                 m_tready;
    logic [47:0]          m_tdata;   // [31:0] chunk_block, [35:32] chunk_log2,
                                     // [40:36] byte_log2, [47:41] zero
    logic                 m_tuser;   // [0] chunk_is_write
    logic                 m_tlast;   // last_chunk

    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Mirror of the cap registers, updated when a config beat is accepted.
    logic [CFG_DAT_W-1:0] cap_read;
    logic [CFG_DAT_W-1:0] cap_write;

    // Chunks predicted but not yet seen on the m_ side, oldest first.
    chunk_t pending_chunks[$];

    int mismatch_count;
    int send_idle_pct;
    int recv_idle_pct;

    io_request_splitter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Split one accepted request into the chunks the block must emit.
    // Chunk size is the lowest set bit of what remains, capped per direction;
    // the cap register is clamped to the supported range before use.
    function automatic void split_request(input logic wr, input logic [BLOCK_W-1:0] blk,
                                          input logic [7:0] cnt);
        int             cap;
        int             remain;
        int             lg;
        int             n;
        logic [BLOCK_W-1:0] used;
        chunk_t         c;
        cap = wr ? int'(cap_write) : int'(cap_read);
        if (cap < CAP_MIN) begin
            cap = CAP_MIN;
        end else if (cap > CAP_MAX) begin
            cap = CAP_MAX;
        end
        remain = int'(cnt);
        used   = '0;
        n      = 0;
        // A zero count drops out here without any chunk.
        while (remain != 0 && n < MAX_CHUNKS) begin
            lg = 0;
            while (lg < cap && ((remain >> lg) & 1) == 0) begin
                lg++;
            end
            remain -= (1 << lg);
            c.blk  = blk + used;                  // wraps modulo 2^32
            c.lg   = LOG2_W'(lg);
            c.lenp = LEN_W'(lg + SECTOR_LOG2);
            c.wr   = wr;
            // Close the request when nothing remains or the chunk budget runs
            // out; anything still left after the budget is dropped.
            c.last = (remain == 0) || (n + 1 == MAX_CHUNKS);
            pending_chunks.push_back(c);
            used += BLOCK_W'(1 << lg);
            n++;
        end
    endfunction

    // Receiver: stall m_tready at random, redrawn every cycle.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check every accepted chunk beat against the oldest prediction.
    always @(posedge aclk) begin
        chunk_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chunks.size() == 0) begin
                $error("unexpected chunk beat: tdata %h tuser %b tlast %b",
                       m_tdata, m_tuser, m_tlast);
                mismatch_count++;
            end else begin
                e = pending_chunks.pop_front();
                if (m_tdata[31:0] !== e.blk) begin
                    $error("chunk_block: expected %h, got %h", e.blk, m_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_tdata[35:32] !== e.lg) begin
                    $error("chunk_log2: expected %0d, got %0d", e.lg, m_tdata[35:32]);
                    mismatch_count++;
                end
                if (m_tdata[40:36] !== e.lenp) begin
                    $error("byte_log2: expected %0d, got %0d", e.lenp, m_tdata[40:36]);
                    mismatch_count++;
                end
                if (m_tuser !== e.wr) begin
                    $error("chunk_is_write: expected %b, got %b", e.wr, m_tuser);
                    mismatch_count++;
                end
                if (m_tlast !== e.last) begin
                    $error("last_chunk: expected %b, got %b", e.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Send one request beat; predict its chunks at the accepting edge.
    // Returns at a falling edge with s_tvalid still high, so a following
    // request goes out back to back.
    task automatic send_request(input logic wr, input logic [BLOCK_W-1:0] blk,
                                input logic [7:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cnt, blk};
        s_tuser  <= wr;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        split_request(wr, blk, cnt);
        @(negedge aclk);
    endtask

    // Hold off the sender until every predicted chunk has arrived, then let
    // the block settle, since a zero-count request leaves nothing to wait on.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_chunks.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    // Write both cap registers back to back; only called with the block idle.
    task automatic program_caps(input logic [CFG_DAT_W-1:0] rd_cap,
                                input logic [CFG_DAT_W-1:0] wr_cap);
        cfg_valid <= 1'b1;
        cfg_index <= REG_MAX_READ;
        cfg_data  <= rd_cap;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cap_read = rd_cap;
        @(negedge aclk);
        cfg_index <= REG_MAX_WRITE;
        cfg_data  <= wr_cap;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cap_write = wr_cap;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Reset caps: single sector, wrap past the top sector, power of two at the
    // cap, every bit of the count set, and zero counts in both directions.
    task automatic test_reset_caps();
        send_request(1'b0, 32'h0000_0000, 8'd1);
        send_request(1'b1, 32'hFFFF_FFFF, 8'd3);
        send_request(1'b0, 32'h1234_5678, 8'd128);
        send_request(1'b1, 32'hFFFF_FFF0, 8'd255);
        send_request(1'b0, 32'hAAAA_5555, 8'd0);
        send_request(1'b1, 32'h5555_AAAA, 8'd0);
        send_request(1'b0, 32'h8000_0000, 8'd96);
        wait_for_drain();
    endtask

    // Cap register extremes: values below the floor and above the ceiling,
    // and the chunk overflow that a full count under the smallest cap causes.
    task automatic test_cap_extremes();
        program_caps(4'd0, 4'd15);
        send_request(1'b0, 32'h0000_0000, 8'd255);   // overflow, read side
        send_request(1'b1, 32'hFFFF_FF80, 8'd255);
        send_request(1'b1, 32'h0000_1000, 8'd128);
        send_request(1'b0, 32'h0000_2000, 8'd128);
        send_request(1'b0, 32'h0000_3000, 8'd4);
        wait_for_drain();

        program_caps(4'd8, 4'd1);
        send_request(1'b0, 32'h7FFF_FFFF, 8'd255);
        send_request(1'b1, 32'hFFFF_FFFE, 8'd255);   // overflow, write side
        send_request(1'b1, 32'h0000_0010, 8'd3);
        send_request(1'b0, 32'h0F0F_0F0F, 8'd200);
        wait_for_drain();

        program_caps(4'd9, 4'd2);
        send_request(1'b0, 32'hC000_0000, 8'd255);
        send_request(1'b1, 32'h3FFF_FFFF, 8'd255);
        send_request(1'b1, 32'h0000_0000, 8'd64);
        wait_for_drain();
    endtask

    // Random requests under random caps, in segments separated by a drain so
    // that the caps can be reprogrammed while the block is idle.
    task automatic test_random_traffic(input int snd_idle, input int rcv_idle);
        logic [CFG_DAT_W-1:0] rd_cap;
        logic [CFG_DAT_W-1:0] wr_cap;
        logic [BLOCK_W-1:0]   blk;
        logic [7:0]           cnt;
        int                   pick;
        send_idle_pct = snd_idle;
        recv_idle_pct = rcv_idle;
        for (int seg = 0; seg < 3; seg++) begin
            rd_cap = ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom_range(15))
                                              : CFG_DAT_W'($urandom_range(8, 2));
            wr_cap = ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom_range(15))
                                              : CFG_DAT_W'($urandom_range(8, 2));
            program_caps(rd_cap, wr_cap);
            for (int k = 0; k < 30; k++) begin
                pick = $urandom_range(9);
                case (pick)
                    0: begin
                        cnt = 8'(1 << $urandom_range(7));
                    end
                    1: begin
                        cnt = $urandom_range(1) ? 8'd255 : 8'd0;
                    end
                    default: begin
                        cnt = 8'($urandom_range(255, 1));
                    end
                endcase
                // Start some requests just below the top so chunks wrap.
                blk = ($urandom_range(4) == 0) ? (32'hFFFF_FF00 | 32'($urandom_range(255)))
                                               : 32'($urandom);
                send_request(1'($urandom_range(1)), blk, cnt);
            end
            wait_for_drain();
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_MAX_READ;
        cfg_data       = '0;
        cap_read       = CAP_RESET;
        cap_write      = CAP_RESET;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_idle_pct  = 0;

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_caps();
        test_cap_extremes();
        test_random_traffic(33, 52);
        test_random_traffic(52, 33);
        test_random_traffic(0, 0);
        wait_for_drain();

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/iors_pkg.sv
rtl/iors_dp.sv
rtl/iors_ctrl.sv
rtl/io_request_splitter_core.sv
tb/io_request_splitter_core_tb.sv
